@@ hw/rtl/frustum_aabb_cull_macros.svh @@
// Assertion macros for the frustum box culler.
// Included by the top level; no other dependencies.
`ifndef FRUSTUM_AABB_CULL_MACROS_SVH
`define FRUSTUM_AABB_CULL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define FAC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define FAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FAC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define FAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/fac_pkg.sv @@
// Shared types, constants and helpers for the frustum box culler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fac_pkg;

    localparam int PLANE_COUNT  = 6;   // cells in the chain, 1..8
    localparam int COORD_WIDTH  = 16;  // coordinate width inside the chain, 8..32
    localparam int REG_COUNT    = 6;   // writable plane registers
    localparam int CFG_IDX_W    = $clog2(REG_COUNT);
    localparam int PLANE_W      = 64;
    localparam int FIELD_W      = 16;  // width of one coordinate field on the bus
    localparam int NORM_W       = 16;  // Q4.11
    localparam int OFFSET_W     = 16;  // Q8.8
    localparam int OFFSET_SHIFT = 11;  // align Q8.8 offset to the Q.19 products
    localparam int D_SHIFTED_W  = OFFSET_W + OFFSET_SHIFT;
    localparam int PROD_W       = NORM_W + COORD_WIDTH;
    localparam int DIST_W       = ((PROD_W > D_SHIFTED_W) ? PROD_W : D_SHIFTED_W) + 2;
    localparam int AXES         = 3;
    localparam int IN_TDATA_W   = 2 * AXES * FIELD_W;
    localparam int VERDICT_W    = 2;
    localparam int OUT_TDATA_W  = 8;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [NORM_W-1:0]      t_norm;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [DIST_W-1:0]      t_dist;

    typedef struct packed {
        t_coord [AXES-1:0] hi;
        t_coord [AXES-1:0] lo;
    } t_box;

    // Control that travels with each box down the chain.
    typedef struct packed {
        logic valid;
        logic any_out;
        logic any_cross;
    } t_tag;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OUTSIDE = 2'd0,
        VERDICT_CROSS   = 2'd1,
        VERDICT_INSIDE  = 2'd2
    } t_verdict;

    // Bus field to chain coordinate: sign comes from bit COORD_WIDTH-1.
    function automatic t_coord coord_of(input logic [FIELD_W-1:0] f);
        logic [31:0] w;
        w = {{(32-FIELD_W){1'b0}}, f};
        return signed'(w[COORD_WIDTH-1:0]);
    endfunction

endpackage

@@ hw/rtl/frustum_aabb_cull.sv @@
// Top level of the frustum box culler: plane cell chain plus output stage.
// Uses fac_pkg, fac_cell, fac_out and frustum_aabb_cull_macros.svh.
//
// channel   dir  handshake                          payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  box min/max xyz, Q8.8
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  verdict
// cfg       in   i_cfg_we                            plane index, 64-bit plane
//
// One box enters per cycle unless a held result stalls the chain. Every plane cell
// holds a multiply stage and a sum-and-sign stage; the output register adds one more.
// Synchronous active-low reset clears all valid flags and all plane registers;
// with all-zero planes every box comes out inside.
// A held result at the output stalls the whole chain at once; input ready
// drops only in that case, so the chain never drops or repeats an item.
`timescale 1ns / 1ps
`include "frustum_aabb_cull_macros.svh"

module frustum_aabb_cull import fac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // box in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // bits up from 0: min_x, min_y, min_z, max_x, max_y, max_z (16 each)
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    // verdict out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // bits up from 0: verdict (2), zero fill (6)
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // plane configuration: 0 near, 1 far, 2 left, 3 right, 4 top, 5 bottom
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [PLANE_W-1:0]    i_cfg_data
);

    logic     w_en;
    t_box     w_box [PLANE_COUNT];
    t_tag     w_tag [PLANE_COUNT+1];
    t_verdict w_verdict;

    // unpack the box; the chain head sees valid straight from the bus
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_box[0].lo[a] = coord_of(i_s_axis_tdata[FIELD_W*a +: FIELD_W]);
            w_box[0].hi[a] = coord_of(i_s_axis_tdata[FIELD_W*(a+AXES) +: FIELD_W]);
        end
        w_tag[0].valid     = i_s_axis_tvalid;
        w_tag[0].any_out   = 1'b0;
        w_tag[0].any_cross = 1'b0;
    end

    assign o_s_axis_tready = w_en;

    // one cell per plane; cells past the writable registers keep zero planes
    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
        logic w_cell_we;
        assign w_cell_we = i_cfg_we && (i < REG_COUNT) &&
                           (i_cfg_index == CFG_IDX_W'(i));
        if (i == PLANE_COUNT - 1) begin : g_last
            fac_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (w_en),
                .i_cfg_we   (w_cell_we),
                .i_cfg_data (i_cfg_data),
                .i_box      (w_box[i]),
                .i_tag      (w_tag[i]),
                .o_box      (),
                .o_tag      (w_tag[i+1])
            );
        end else begin : g_mid
            fac_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (w_en),
                .i_cfg_we   (w_cell_we),
                .i_cfg_data (i_cfg_data),
                .i_box      (w_box[i]),
                .i_tag      (w_tag[i]),
                .o_box      (w_box[i+1]),
                .o_tag      (w_tag[i+1])
            );
        end
    end

    // fold flags by priority and hold the result for the sink
    fac_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (w_tag[PLANE_COUNT]),
        .i_tready  (i_m_axis_tready),
        .o_en      (w_en),
        .o_tvalid  (o_m_axis_tvalid),
        .o_verdict (w_verdict)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-VERDICT_W){1'b0}}, w_verdict};

    // a stall must freeze the chain tail
    `FAC_ASSERT_NEXT(a_stall_holds_tail, i_clk, i_rst_n, !w_en, $stable(w_tag[PLANE_COUNT]), "chain moved during stall")
    // an item leaving the last cell must land in the output register
    `FAC_ASSERT_NEXT(a_tail_reaches_out, i_clk, i_rst_n, w_tag[PLANE_COUNT].valid && w_en, o_m_axis_tvalid, "item lost at output stage")
    // a shown verdict is a legal code with zero fill
    `FAC_ASSERT_IMPLY(a_verdict_legal, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[1:0] != 2'd3) && (o_m_axis_tdata[7:2] == 6'd0), "illegal verdict code")

endmodule

@@ hw/rtl/fac_cell.sv @@
// One plane cell of the culling chain: holds a plane register, scores the
// p- and n-vertex of the passing box and hands box and flags on. Uses fac_pkg.
`timescale 1ns / 1ps

module fac_cell import fac_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_cfg_we,
    input  logic [PLANE_W-1:0] i_cfg_data,
    input  t_box               i_box,
    input  t_tag               i_tag,
    output t_box               o_box,
    output t_tag               o_tag
);

    logic [PLANE_W-1:0] r_plane;
    t_norm              w_n [AXES];
    t_norm              w_d;
    t_dist              w_dterm;

    // stage A: products
    t_box  r_a_box;
    t_tag  r_a_tag;
    t_prod r_plo [AXES];
    t_prod r_phi [AXES];

    // stage B: sums and sign tests
    t_dist w_pd;
    t_dist w_nd;
    t_box  r_b_box;
    t_tag  r_b_tag;
    t_tag  n_b_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_we) begin
            r_plane <= i_cfg_data;
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_n[a] = signed'(r_plane[NORM_W*a +: NORM_W]);
        end
        w_d     = signed'(r_plane[PLANE_W-1 -: OFFSET_W]);
        w_dterm = signed'({{(DIST_W-D_SHIFTED_W){w_d[OFFSET_W-1]}}, w_d,
                           {OFFSET_SHIFT{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else if (i_en) begin
            r_a_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_box <= i_box;
            for (int a = 0; a < AXES; a++) begin
                r_plo[a] <= w_n[a] * signed'(i_box.lo[a]);
                r_phi[a] <= w_n[a] * signed'(i_box.hi[a]);
            end
        end
    end

    // p-vertex takes hi where n > 0, n-vertex takes hi where n < 0
    always_comb begin
        w_pd = w_dterm;
        w_nd = w_dterm;
        for (int a = 0; a < AXES; a++) begin
            w_pd = w_pd + t_dist'((!w_n[a][NORM_W-1] && (w_n[a] != '0)) ? r_phi[a]
                                                                        : r_plo[a]);
            w_nd = w_nd + t_dist'(w_n[a][NORM_W-1] ? r_phi[a] : r_plo[a]);
        end
        n_b_tag.valid     = r_a_tag.valid;
        n_b_tag.any_out   = r_a_tag.any_out | w_pd[DIST_W-1];
        n_b_tag.any_cross = r_a_tag.any_cross | w_nd[DIST_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
        end else if (i_en) begin
            r_b_tag <= n_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_box <= r_a_box;
        end
    end

    assign o_box = r_b_box;
    assign o_tag = r_b_tag;

endmodule

@@ hw/rtl/fac_out.sv @@
// Output stage of the culler: folds the chain flags into a verdict by
// priority and holds it for the downstream handshake. Uses fac_pkg.
`timescale 1ns / 1ps

module fac_out import fac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tag     i_tag,
    input  logic     i_tready,
    output logic     o_en,
    output logic     o_tvalid,
    output t_verdict o_verdict
);

    logic     r_valid;
    t_verdict r_verdict;
    t_verdict n_verdict;

    // advance the whole chain unless a result is held
    assign o_en = !r_valid || i_tready;

    always_comb begin
        priority if (i_tag.any_out) begin
            n_verdict = VERDICT_OUTSIDE;
        end else if (i_tag.any_cross) begin
            n_verdict = VERDICT_CROSS;
        end else begin
            n_verdict = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_tvalid  = r_valid;
    assign o_verdict = r_verdict;

endmodule

@@ sim/frustum_aabb_cull_tb.sv @@
// Self-checking bench for the frustum box culler: streams boxes against several plane sets.
// Predicts every verdict from its own copy of the planes; needs fac_pkg and frustum_aabb_cull.
`timescale 1ns / 1ps

module frustum_aabb_cull_tb;
    import fac_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 9;
    localparam int TIMEOUT_CYCLES  = 200000;
    // Pipeline depth plus margin; used as the settle time before plane writes and at the end.
    localparam int DRAIN_CYCLES    = 2 * PLANE_COUNT + 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 6;
    localparam int BOXES_PER_PHASE = 215;
    localparam int SLOT_COUNT      = 8;
    localparam int NORM_ONE        = 2048;   // 1.0 in Q4.11

    typedef enum int {
        PLANE_NEAR, PLANE_FAR, PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM
    } plane_idx_e;

    typedef enum int {FLOW_FREE, SEND_GAPS, RECV_STALLS, BOTH_IDLE} flow_e;

    // Same layout as the input bus: min_x in the lowest bits.
    typedef struct packed {
        logic [15:0] max_z, max_y, max_x, min_z, min_y, min_x;
    } box_t;

    // Same layout as a plane register: nx in the lowest bits.
    typedef struct packed {
        logic [15:0] offs, nz, ny, nx;
    } plane_t;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [PLANE_W-1:0]     i_cfg_data      = '0;
    wire                    o_s_axis_tready;
    wire                    o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  o_m_axis_tdata;

    // Bench copy of the plane registers; slots past the writable ones stay zero.
    plane_t   plane_regs [SLOT_COUNT] = '{default: '0};
    box_t     pending_boxes [$];
    t_verdict verdicts_due [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_ask       = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int          mismatches     = 0;
    int unsigned cycle_count    = 0;

    frustum_aabb_cull dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // min_x, min_y, min_z, max_x, max_y, max_z
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // verdict (2), zero fill (6)
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------

    // Sign-extend a bus field from the chain's coordinate width.
    function automatic longint coord_value(input logic [15:0] field);
        longint v;
        v = longint'(field) & ((longint'(1) << COORD_WIDTH) - 1);
        if (v[COORD_WIDTH-1]) v -= longint'(1) << COORD_WIDTH;
        return v;
    endfunction

    // p/n-vertex test over the live planes. Distances carry 19 fraction bits and are
    // exact in 64 bits; a distance of zero sits on the plane and never counts as below.
    function automatic t_verdict classify_box(input box_t b);
        longint      lo [3];
        longint      hi [3];
        logic [15:0] nrm [3];
        longint      n, pos_dist, neg_dist;
        bit          any_outside, any_cross;
        any_outside = 1'b0;
        any_cross   = 1'b0;
        lo[0] = coord_value(b.min_x);
        lo[1] = coord_value(b.min_y);
        lo[2] = coord_value(b.min_z);
        hi[0] = coord_value(b.max_x);
        hi[1] = coord_value(b.max_y);
        hi[2] = coord_value(b.max_z);
        for (int p = 0; p < PLANE_COUNT && p < SLOT_COUNT; p++) begin
            nrm[0]   = plane_regs[p].nx;
            nrm[1]   = plane_regs[p].ny;
            nrm[2]   = plane_regs[p].nz;
            pos_dist = longint'(signed'(plane_regs[p].offs)) * (longint'(1) << OFFSET_SHIFT);
            neg_dist = pos_dist;
            for (int a = 0; a < 3; a++) begin
                n = longint'(signed'(nrm[a]));
                // A zero component takes the minimum for both vertices.
                pos_dist += n * ((n > 0) ? hi[a] : lo[a]);
                neg_dist += n * ((n < 0) ? hi[a] : lo[a]);
            end
            if (pos_dist < 0) any_outside = 1'b1;
            if (neg_dist < 0) any_cross = 1'b1;
        end
        if (any_outside) return VERDICT_OUTSIDE;
        if (any_cross) return VERDICT_CROSS;
        return VERDICT_INSIDE;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Box sender: hold an offered item until it is taken, then predict its verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                verdicts_due.push_back(classify_box(pending_boxes.pop_front()));
            end
            // Only choose a new item once the current one is gone (or none was offered).
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_boxes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pending_boxes[0];
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off: count down in cycles once the sequencer asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Verdict receiver: stall at random, and fully during a hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each taken verdict with the oldest prediction; the fill bits must be zero.
    always @(posedge i_clk) begin : verdict_monitor
        t_verdict want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict byte %0h with none expected",
                                          o_m_axis_tdata));
            end else begin
                want = verdicts_due.pop_front();
                if (o_m_axis_tdata !== OUT_TDATA_W'(want))
                    report_mismatch($sformatf("verdict byte %0h, expected %s",
                                              o_m_axis_tdata, want.name()));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("frustum_aabb_cull_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic box_t mk_box(input int mnx, mny, mnz, mxx, mxy, mxz);
        box_t b;
        b.min_x = 16'(mnx);
        b.min_y = 16'(mny);
        b.min_z = 16'(mnz);
        b.max_x = 16'(mxx);
        b.max_y = 16'(mxy);
        b.max_z = 16'(mxz);
        return b;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Mostly boxes around the origin with random extent; some snapped onto a face
    // distance, some fully random bit patterns, some with min above max.
    function automatic box_t random_box(input int span, input int ext, input int snap);
        int lo [3];
        int hi [3];
        int c, e, kind, a, t;
        box_t b;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            b = {$urandom, $urandom, $urandom};
            return b;
        end
        for (int i = 0; i < 3; i++) begin
            c     = int'($urandom_range(0, 2 * span)) - span;
            e     = $urandom_range(0, ext);
            lo[i] = clamp_coord(c - e);
            hi[i] = clamp_coord(c + e);
        end
        if (kind < 35) begin
            a = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: lo[a] = snap;
                1: hi[a] = snap;
                2: lo[a] = -snap;
                default: hi[a] = -snap;
            endcase
        end
        if (kind >= 90) begin
            for (int i = 0; i < 3; i++) begin
                t     = lo[i];
                lo[i] = hi[i];
                hi[i] = t;
            end
        end
        return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // Axis-aligned slab face: even slots face +axis, odd slots face -axis.
    function automatic plane_t cube_plane(input int slot, input int half);
        plane_t pl;
        int     n;
        pl = '0;
        n  = (slot % 2 == 0) ? NORM_ONE : -NORM_ONE;
        case (slot / 2)
            0: pl.nx = 16'(n);
            1: pl.ny = 16'(n);
            default: pl.nz = 16'(n);
        endcase
        pl.offs = 16'(half);
        return pl;
    endfunction

    // Tilted plane with the origin on its inner side; components are zero now and then.
    function automatic plane_t tilted_plane();
        plane_t pl;
        pl.nx   = ($urandom_range(0, 5) == 0) ? 16'h0 : 16'(int'($urandom_range(0, 4096)) - 2048);
        pl.ny   = ($urandom_range(0, 5) == 0) ? 16'h0 : 16'(int'($urandom_range(0, 4096)) - 2048);
        pl.nz   = ($urandom_range(0, 5) == 0) ? 16'h0 : 16'(int'($urandom_range(0, 4096)) - 2048);
        pl.offs = 16'($urandom_range(16'h0400, 16'h3000));
        return pl;
    endfunction

    function automatic logic [15:0] extreme_field();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic plane_t extreme_plane();
        plane_t pl;
        pl.nx   = extreme_field();
        pl.ny   = extreme_field();
        pl.nz   = extreme_field();
        pl.offs = extreme_field();
        return pl;
    endfunction

    // One register write per clock; writes past the last plane are dropped by the block.
    task automatic write_reg(input int idx, input plane_t value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data  <= value;
        if (idx < REG_COUNT) plane_regs[idx] = value;
    endtask

    task automatic cfg_release();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_flow(input flow_e f);
        send_idle_pct  = (f == SEND_GAPS) ? 47 : (f == BOTH_IDLE) ? 10 : 0;
        recv_stall_pct = (f == RECV_STALLS) ? 47 : (f == BOTH_IDLE) ? 10 : 0;
    endtask

    // Wait until every item is taken and every verdict is back, then let the chain settle.
    task automatic drain();
        @(negedge i_clk);
        while (pending_boxes.size() != 0 || verdicts_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        int half, span, ext, snap;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_flow(FLOW_FREE);

        // Reset planes are all zero: every box lands inside, extremes included.
        @(negedge i_clk);
        pending_boxes.push_back(mk_box(0, 0, 0, 0, 0, 0));
        pending_boxes.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_boxes.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        pending_boxes.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        pending_boxes.push_back(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        pending_boxes.push_back(mk_box('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA));
        drain();

        // Cube of half-width 16.0, then junk to the unused indexes, which must not land.
        for (int p = PLANE_NEAR; p <= PLANE_BOTTOM; p++) write_reg(p, cube_plane(p, 'h1000));
        for (int idx = REG_COUNT; idx < (1 << CFG_IDX_W); idx++)
            write_reg(idx, plane_t'({$urandom, $urandom}));
        cfg_release();

        @(negedge i_clk);
        pending_boxes.push_back(mk_box(-'h800, -'h800, -'h800, 'h800, 'h800, 'h800));
        pending_boxes.push_back(mk_box('h1400, 0, 0, 'h1800, 'h100, 'h100));
        pending_boxes.push_back(mk_box(0, 0, -'h3000, 'h100, 'h100, -'h2000));
        pending_boxes.push_back(mk_box(-'h1800, 0, 0, 0, 'h100, 'h100));
        // Max on the -16 face from outside: on the plane, so crossing rather than outside.
        pending_boxes.push_back(mk_box(-'h1800, 0, 0, -'h1000, 'h100, 'h100));
        // One LSB further out is outside.
        pending_boxes.push_back(mk_box(-'h1800, 0, 0, -'h1001, 'h100, 'h100));
        // Faces exactly on both x planes: still inside.
        pending_boxes.push_back(mk_box(-'h1000, 0, 0, 'h1000, 'h100, 'h100));
        pending_boxes.push_back(mk_box('h1000, 'h1000, 'h1000, 'h1000, 'h1000, 'h1000));
        pending_boxes.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        // Min above max runs unswapped.
        pending_boxes.push_back(mk_box('h800, 'h800, 'h800, -'h800, -'h800, -'h800));
        pending_boxes.push_back(mk_box('h1800, 0, 0, -'h1800, 0, 0));
        pending_boxes.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_boxes.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            half = $urandom_range('h0200, 'h2000);
            case (ph)
                0, 3: begin
                    for (int p = PLANE_NEAR; p <= PLANE_BOTTOM; p++)
                        write_reg(p, cube_plane(p, half));
                    span = half + 'h400;
                    ext  = half / 2;
                    snap = half;
                end
                1, 2: begin
                    for (int p = PLANE_NEAR; p <= PLANE_BOTTOM; p++) write_reg(p, tilted_plane());
                    // Drop one plane back to zero so it can never reject.
                    if (ph == 1) write_reg(PLANE_BOTTOM, '0);
                    span = 'h2000;
                    ext  = 'h0C00;
                    snap = 0;
                end
                4: begin
                    for (int p = PLANE_NEAR; p <= PLANE_BOTTOM; p++) write_reg(p, extreme_plane());
                    span = 'h7FFF;
                    ext  = 'h4000;
                    snap = 'h7FFF;
                end
                default: begin
                    // Mix every style of plane in one set.
                    for (int p = PLANE_NEAR; p <= PLANE_BOTTOM; p++) begin
                        case ($urandom_range(0, 3))
                            0: write_reg(p, cube_plane(p, half));
                            1: write_reg(p, tilted_plane());
                            2: write_reg(p, extreme_plane());
                            default: write_reg(p, plane_t'({$urandom, $urandom}));
                        endcase
                    end
                    span = 'h3000;
                    ext  = 'h1000;
                    snap = half;
                end
            endcase
            cfg_release();

            case (ph)
                0, 4: set_flow(FLOW_FREE);
                1: set_flow(SEND_GAPS);
                2, 5: set_flow(RECV_STALLS);
                default: set_flow(BOTH_IDLE);
            endcase

            @(negedge i_clk);
            // Back-pressure the output long enough for the chain to fill and stall the input.
            if (ph == 0) hold_ask++;
            for (int k = 0; k < BOXES_PER_PHASE; k++)
                pending_boxes.push_back(random_box(span, ext, snap));
            drain();
        end

        if (mismatches == 0) begin
            $display("frustum_aabb_cull_tb passed");
        end else begin
            $display("frustum_aabb_cull_tb failed");
        end
        $finish;
    end

endmodule
